// ===== hdl/lut_1d_linear_interp_top_defines.svh =====
// Assertion macros used by the interpolator port checker.
`ifndef LUT_1D_LINEAR_INTERP_TOP_DEFINES_SVH
`define LUT_1D_LINEAR_INTERP_TOP_DEFINES_SVH

// Check a same-cycle implication on the port clock.
`define LLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication on the next cycle of the port clock.
`define LLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lli_pkg.sv =====
// Shared types and constants of the 1D table interpolator.
package lli_pkg;

  localparam int unsigned LLI_TABLE_DEPTH = 1024;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned DIV_W  = VAL_W + 1;
  localparam int unsigned P_W    = DIV_W + LEN_W;
  localparam int unsigned PROD_W = DIV_W + DIV_W;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
  localparam logic [ST_W-1:0] ST_DOMAIN = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_AW-1:0] REG_DOMAIN_LOW   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DOMAIN_HIGH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CLIP_MODE    = 2'd2;
  localparam logic [CFG_AW-1:0] REG_TABLE_LENGTH = 2'd3;

  localparam logic [VAL_W-1:0] RST_DOMAIN_LOW   = 32'd0;
  localparam logic [VAL_W-1:0] RST_DOMAIN_HIGH  = 32'd65536;
  localparam logic             RST_CLIP_MODE    = 1'b1;
  localparam logic [LEN_W-1:0] RST_TABLE_LENGTH = 11'd2;

  typedef enum logic [1:0] {
    SEL_INTERP,
    SEL_LOW,
    SEL_HIGH
  } sel_e;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic [ST_W-1:0]  st;
    sel_e             sel;
    logic [LEN_W-1:0] nm1;
  } lli_meta_t;

  typedef struct packed {
    logic [VAL_W-1:0] y0;
    logic             neg;
    logic [ST_W-1:0]  st;
  } lli_tail_t;

endpackage

// ===== hdl/lli_div_cell.sv =====
// One restoring-division cell: resolves a single quotient bit and hands on.
module lli_div_cell #(
  parameter int unsigned DW    = 44,
  parameter int unsigned VW    = 33,
  parameter int unsigned QW    = 11,
  parameter int unsigned SW    = 1,
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_v_i,
  input  logic [DW-1:0] in_r_i,
  input  logic [QW-1:0] in_q_i,
  input  logic [VW-1:0] in_d_i,
  input  logic [SW-1:0] in_side_i,
  output logic          out_v_o,
  output logic [DW-1:0] out_r_o,
  output logic [QW-1:0] out_q_o,
  output logic [VW-1:0] out_d_o,
  output logic [SW-1:0] out_side_o
);

  logic [DW-1:0] shifted;
  logic          ge;
  logic [DW-1:0] r_d;
  logic [QW-1:0] q_d;
  logic          v_q;
  logic [DW-1:0] r_q;
  logic [QW-1:0] q_q;
  logic [VW-1:0] d_q;
  logic [SW-1:0] side_q;

  // Trial subtract of the divisor at this bit weight
  always_comb begin
    shifted   = DW'(in_d_i) << SHIFT;
    ge        = (in_r_i >= shifted);
    r_d       = ge ? (in_r_i - shifted) : in_r_i;
    q_d       = in_q_i;
    q_d[SHIFT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= in_v_i;
    end
  end

  // Advance payload with the pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_d;
      q_q    <= q_d;
      d_q    <= in_d_i;
      side_q <= in_side_i;
    end
  end

  assign out_v_o    = v_q;
  assign out_r_o    = r_q;
  assign out_q_o    = q_q;
  assign out_d_o    = d_q;
  assign out_side_o = side_q;

endmodule

// ===== hdl/lli_div_chain.sv =====
// Row of division cells, most significant quotient bit first.
module lli_div_chain #(
  parameter int unsigned VW = 33,
  parameter int unsigned QW = 11,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_v_i,
  input  logic [VW+QW-1:0] dividend_i,
  input  logic [VW-1:0]    divisor_i,
  input  logic [SW-1:0]    in_side_i,
  output logic             out_v_o,
  output logic [QW-1:0]    quotient_o,
  output logic [VW-1:0]    remainder_o,
  output logic [VW-1:0]    divisor_o,
  output logic [SW-1:0]    out_side_o
);

  localparam int unsigned DW = VW + QW;

  logic          v_w    [QW+1];
  logic [DW-1:0] r_w    [QW+1];
  logic [QW-1:0] q_w    [QW+1];
  logic [VW-1:0] d_w    [QW+1];
  logic [SW-1:0] side_w [QW+1];

  assign v_w[0]    = in_v_i;
  assign r_w[0]    = dividend_i;
  assign q_w[0]    = '0;
  assign d_w[0]    = divisor_i;
  assign side_w[0] = in_side_i;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    lli_div_cell #(
      .DW   (DW),
      .VW   (VW),
      .QW   (QW),
      .SW   (SW),
      .SHIFT(QW - 1 - k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en_i),
      .in_v_i    (v_w[k]),
      .in_r_i    (r_w[k]),
      .in_q_i    (q_w[k]),
      .in_d_i    (d_w[k]),
      .in_side_i (side_w[k]),
      .out_v_o   (v_w[k+1]),
      .out_r_o   (r_w[k+1]),
      .out_q_o   (q_w[k+1]),
      .out_d_o   (d_w[k+1]),
      .out_side_o(side_w[k+1])
    );
  end

  assign out_v_o     = v_w[QW];
  assign quotient_o  = q_w[QW];
  assign remainder_o = r_w[QW][VW-1:0];
  assign divisor_o   = d_w[QW];
  assign out_side_o  = side_w[QW];

endmodule

// ===== hdl/lut_1d_linear_interp_top.sv =====
// Path: input registers, knot division row, table and slope registers, step division row, output register.
// Throughput: one beat per cycle while the output is not stalled; two division cell rows set the depth.
// Table writes take the same pipe and land in the table at the lookup stage.
// The pipe freezes only while a finished result is held and not taken.
// Reset (async, active low) clears valids and sets config to its reset values; the table is not cleared.
module lut_1d_linear_interp_top #(
  parameter int unsigned TABLE_DEPTH = lli_pkg::LLI_TABLE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lli_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [lli_pkg::VAL_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [lli_pkg::IDX_W-1:0]   entry_index_i,
  input  logic signed [lli_pkg::VAL_W-1:0] entry_value_i,
  input  logic signed [lli_pkg::VAL_W-1:0] query_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [lli_pkg::VAL_W-1:0] mapped_value_o,
  output logic [lli_pkg::ST_W-1:0]    status_o
);

  import lli_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // configuration
  logic signed [VAL_W-1:0] dom_lo_q, dom_hi_q;
  logic                    clip_q;
  logic [LEN_W-1:0]        len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_lo_q <= RST_DOMAIN_LOW;
      dom_hi_q <= RST_DOMAIN_HIGH;
      clip_q   <= RST_CLIP_MODE;
      len_q    <= RST_TABLE_LENGTH;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DOMAIN_LOW:   dom_lo_q <= cfg_wdata_i;
        REG_DOMAIN_HIGH:  dom_hi_q <= cfg_wdata_i;
        REG_CLIP_MODE:    clip_q   <= cfg_wdata_i[0];
        REG_TABLE_LENGTH: len_q    <= cfg_wdata_i[LEN_W-1:0];
      endcase
    end
  end

  logic en;
  logic pre_v;
  logic out_v_q;

  // Freeze only when the last stage holds a result the output cannot take
  assign en         = !(out_v_q && !out_ready_i && pre_v);
  assign in_ready_o = en;

  // Stage 1: classify the beat, form offsets
  lli_meta_t        s0_meta;
  logic [DIV_W-1:0] s0_x, s0_d;
  logic [LEN_W-1:0] s0_nm1;

  always_comb begin
    if (len_q < LEN_W'(2)) begin
      s0_nm1 = LEN_W'(1);
    end else if (32'(len_q) > TABLE_DEPTH) begin
      s0_nm1 = LEN_W'(TABLE_DEPTH - 1);
    end else begin
      s0_nm1 = len_q - LEN_W'(1);
    end
    s0_x = {query_i[VAL_W-1], query_i} - {dom_lo_q[VAL_W-1], dom_lo_q};
    s0_d = {dom_hi_q[VAL_W-1], dom_hi_q} - {dom_lo_q[VAL_W-1], dom_lo_q};
    s0_meta.func = func_i;
    s0_meta.idx  = entry_index_i;
    s0_meta.val  = entry_value_i;
    s0_meta.nm1  = s0_nm1;
    s0_meta.st   = ST_OK;
    s0_meta.sel  = SEL_INTERP;
    if (dom_lo_q >= dom_hi_q) begin
      s0_meta.st = ST_DOMAIN;
    end else if (!clip_q && (query_i < dom_lo_q || query_i > dom_hi_q)) begin
      s0_meta.st = ST_REJECT;
    end else if (query_i <= dom_lo_q) begin
      s0_meta.sel = SEL_LOW;
    end else if (query_i >= dom_hi_q) begin
      s0_meta.sel = SEL_HIGH;
    end
  end

  logic             s1_v, s2_v;
  lli_meta_t        s1_meta, s2_meta;
  logic [DIV_W-1:0] s1_x, s1_d, s2_d;
  logic [P_W-1:0]   s2_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid_i;
      s2_v <= s1_v;
    end
  end

  // Stage 2: scale offset by the interval count (knots minus one)
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta <= s0_meta;
      s1_x    <= s0_x;
      s1_d    <= s0_d;
      s2_meta <= s1_meta;
      s2_p    <= P_W'(s1_x) * P_W'(s1_meta.nm1);
      s2_d    <= s1_d;
    end
  end

  // Knot index and remainder
  logic             dv1_v;
  lli_meta_t        dv1_meta;
  logic [LEN_W-1:0] dv1_lower;
  logic [DIV_W-1:0] dv1_rem, dv1_d;

  lli_div_chain #(
    .VW(DIV_W),
    .QW(LEN_W),
    .SW($bits(lli_meta_t))
  ) u_knot_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_v_i     (s2_v),
    .dividend_i (s2_p),
    .divisor_i  (s2_d),
    .in_side_i  (s2_meta),
    .out_v_o    (dv1_v),
    .quotient_o (dv1_lower),
    .remainder_o(dv1_rem),
    .divisor_o  (dv1_d),
    .out_side_o (dv1_meta)
  );

  // Stage 3: table write or read of both neighbors
  logic [VAL_W-1:0] table_mem [TABLE_DEPTH];
  logic [AW-1:0]    rd_a0, rd_a1;
  logic             wr_en;

  always_comb begin
    case (dv1_meta.sel)
      SEL_LOW:  rd_a0 = '0;
      SEL_HIGH: rd_a0 = AW'(dv1_meta.nm1);
      default:  rd_a0 = AW'(dv1_lower);
    endcase
    rd_a1 = rd_a0 + AW'(1);
    wr_en = dv1_v && (dv1_meta.func == FUNC_WRITE) && (32'(dv1_meta.idx) < TABLE_DEPTH);
  end

  logic             s3_v, s4_v, s5_v;
  logic [VAL_W-1:0] s3_y0, s3_y1, s4_y0;
  logic [DIV_W-1:0] s3_rem, s4_rem, s3_d, s4_d, s5_d;
  logic [ST_W-1:0]  s3_st, s4_st;
  logic             s3_interp, s4_neg;
  logic [DIV_W-1:0] s4_mag;
  logic [PROD_W-1:0] s5_prod;
  lli_tail_t        s5_tail;
  logic signed [DIV_W-1:0] s3_diff;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (wr_en) begin
        table_mem[AW'(dv1_meta.idx)] <= dv1_meta.val;
      end
      s3_y0 <= table_mem[rd_a0];
      s3_y1 <= table_mem[rd_a1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (en) begin
      s3_v <= dv1_v && (dv1_meta.func == FUNC_QUERY);
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  assign s3_diff = $signed({s3_y1[VAL_W-1], s3_y1}) - $signed({s3_y0[VAL_W-1], s3_y0});

  // Stages 4 and 5: slope magnitude, then weight it by the remainder
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rem    <= (dv1_meta.sel == SEL_INTERP) ? dv1_rem : '0;
      s3_d      <= dv1_d;
      s3_st     <= dv1_meta.st;
      s3_interp <= (dv1_meta.sel == SEL_INTERP);
      s4_y0     <= s3_y0;
      s4_neg    <= s3_interp && s3_diff[DIV_W-1];
      s4_mag    <= !s3_interp ? '0 :
                   (s3_diff[DIV_W-1] ? DIV_W'(-s3_diff) : DIV_W'(s3_diff));
      s4_rem    <= s3_rem;
      s4_d      <= s3_d;
      s4_st     <= s3_st;
      s5_prod   <= PROD_W'(s4_mag) * PROD_W'(s4_rem);
      s5_d      <= s4_d;
      s5_tail.y0  <= s4_y0;
      s5_tail.neg <= s4_neg;
      s5_tail.st  <= s4_st;
    end
  end

  // Fractional step between the neighbors
  lli_tail_t        dv2_tail;
  logic [DIV_W-1:0] dv2_delta;
  logic [DIV_W-1:0] dv2_rem, dv2_d;

  lli_div_chain #(
    .VW(DIV_W),
    .QW(DIV_W),
    .SW($bits(lli_tail_t))
  ) u_step_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_v_i     (s5_v),
    .dividend_i (s5_prod),
    .divisor_i  (s5_d),
    .in_side_i  (s5_tail),
    .out_v_o    (pre_v),
    .quotient_o (dv2_delta),
    .remainder_o(dv2_rem),
    .divisor_o  (dv2_d),
    .out_side_o (dv2_tail)
  );

  logic [VAL_W-1:0] step;
  logic [VAL_W-1:0] res;

  // Apply the sign and zero the value on error
  always_comb begin
    step = dv2_tail.neg ? (~dv2_delta[VAL_W-1:0] + VAL_W'(1)) : dv2_delta[VAL_W-1:0];
    res  = (dv2_tail.st != ST_OK) ? '0 : (dv2_tail.y0 + step);
  end

  logic [VAL_W-1:0] out_val_q;
  logic [ST_W-1:0]  out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= pre_v;
    end
  end

  // Hold the result until the output beat is taken
  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_val_q <= res;
      out_st_q  <= dv2_tail.st;
    end
  end

  assign out_valid_o    = out_v_q;
  assign mapped_value_o = out_val_q;
  assign status_o       = out_st_q;

endmodule

// ===== hdl/lli_checker.sv =====
// Port-level checker for the interpolator and its bind.
`include "lut_1d_linear_interp_top_defines.svh"

module lli_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [lli_pkg::VAL_W-1:0] mapped_value_o,
  input logic [lli_pkg::ST_W-1:0]  status_o
);

  import lli_pkg::*;

  // A held result beat keeps its payload
  `LLI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(mapped_value_o) && $stable(status_o), "output beat changed while stalled")

  // Error results carry a zero value
  `LLI_ASSERT_NOW(a_err_zero, out_valid_o && status_o != ST_OK, mapped_value_o == '0, "error result with nonzero value")

  // Only known status codes appear
  `LLI_ASSERT_NOW(a_st_code, out_valid_o, status_o == ST_OK || status_o == ST_REJECT || status_o == ST_DOMAIN, "unknown status code")

  // Input stalls only under output backpressure
  `LLI_ASSERT_NOW(a_stall_src, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output backpressure")

endmodule

bind lut_1d_linear_interp_top lli_checker u_lli_checker (.*);

// ===== tb/lut_1d_linear_interp_checker.sv =====
// Channel monitor, interpolation predictor and result comparator for the 1D table block.
module lut_1d_linear_interp_checker
  import lli_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_AW-1:0]       cfg_addr_i,
  input  logic [VAL_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    func_i,
  input  logic [IDX_W-1:0]        entry_index_i,
  input  logic signed [VAL_W-1:0] entry_value_i,
  input  logic signed [VAL_W-1:0] query_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [VAL_W-1:0] mapped_value_i,
  input  logic [ST_W-1:0]         status_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [ST_W-1:0]         st;
  } mapped_t;

  // Shadow of the configuration and the table
  logic signed [VAL_W-1:0] lo_q, hi_q;
  logic                    clip_q;
  logic [LEN_W-1:0]        len_q;
  logic signed [VAL_W-1:0] curve [LLI_TABLE_DEPTH];
  mapped_t                 mapped_q [$];
  int                      fails;

  assign fail_count_o = fails;
  assign pending_o    = mapped_q.size();

  // Map one sample through the shadow table
  function automatic mapped_t map_sample(input logic signed [VAL_W-1:0] q);
    mapped_t            r;
    longint             lo, hi, qs, n, y0, y1, diff;
    longint unsigned    span, pos, knot, rem, mag, delta;
    lo = lo_q;
    hi = hi_q;
    qs = q;
    n  = len_q;
    if (n < 2) n = 2;
    if (n > LLI_TABLE_DEPTH) n = LLI_TABLE_DEPTH;
    r.value = '0;
    r.st    = ST_OK;
    if (lo >= hi) begin
      r.st = ST_DOMAIN;
    end else if (!clip_q && (qs < lo || qs > hi)) begin
      r.st = ST_REJECT;
    end else if (qs <= lo) begin
      r.value = curve[0];
    end else if (qs >= hi) begin
      r.value = curve[n-1];
    end else begin
      span = longint'(hi - lo);
      pos  = longint'(qs - lo) * longint'(n - 1);
      knot = pos / span;
      if (knot > n - 2) knot = n - 2;
      rem  = pos - knot * span;
      if (rem > span) rem = span;
      y0   = curve[knot];
      y1   = curve[knot+1];
      diff = y1 - y0;
      mag  = (diff < 0) ? -diff : diff;
      delta = (mag * rem) / span;
      r.value = (diff < 0) ? y0 - longint'(delta) : y0 + longint'(delta);
    end
    return r;
  endfunction

  // Track config, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    mapped_t want;
    if (!rst_ni) begin
      lo_q   <= RST_DOMAIN_LOW;
      hi_q   <= RST_DOMAIN_HIGH;
      clip_q <= RST_CLIP_MODE;
      len_q  <= RST_TABLE_LENGTH;
      fails  = 0;
      mapped_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_DOMAIN_LOW:   lo_q   <= cfg_wdata_i;
          REG_DOMAIN_HIGH:  hi_q   <= cfg_wdata_i;
          REG_CLIP_MODE:    clip_q <= cfg_wdata_i[0];
          REG_TABLE_LENGTH: len_q  <= cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == FUNC_WRITE) curve[entry_index_i] = entry_value_i;
        else mapped_q.push_back(map_sample(query_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (mapped_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("ERROR: unexpected result value=%0d status=%0d",
                     mapped_value_i, status_i);
        end else begin
          want = mapped_q.pop_front();
          if (want.value !== mapped_value_i || want.st !== status_i) begin
            fails++;
            if (fails <= 10)
              $display("ERROR: expected value=%0d status=%0d, got value=%0d status=%0d",
                       want.value, want.st, mapped_value_i, status_i);
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the 1D table interpolator testbench: clock, reset, stimulus and verdict.
module testbench;
  import lli_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 60;
  localparam int FILL_N      = 65;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]       cfg_addr_i = '0;
  logic [VAL_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    func_i = FUNC_WRITE;
  logic [IDX_W-1:0]        entry_index_i = '0;
  logic signed [VAL_W-1:0] entry_value_i = '0;
  logic signed [VAL_W-1:0] query_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [VAL_W-1:0] mapped_value_o;
  logic [ST_W-1:0]         status_o;

  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  int cycles;
  bit long_stall_req;
  longint dom_lo, dom_hi;

  lut_1d_linear_interp_top u_top (.*);

  lut_1d_linear_interp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .entry_index_i,
    .entry_value_i, .query_i, .out_valid_i(out_valid_o), .out_ready_i,
    .mapped_value_i(mapped_value_o), .status_i(status_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Drive output ready, with an occasional long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req && hold == 0) begin
        long_stall_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one beat, idling first at the sender rate
  task automatic send_beat(input logic f, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] q);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    entry_index_i <= idx;
    entry_value_i <= v;
    query_i       <= q;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_entry(input int idx, input logic [VAL_W-1:0] v);
    send_beat(FUNC_WRITE, IDX_W'(idx), v, $urandom);
  endtask

  task automatic map_query(input logic [VAL_W-1:0] q);
    send_beat(FUNC_QUERY, IDX_W'($urandom), $urandom, q);
  endtask

  // Let the pipe empty before touching registers
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_AW-1:0] addr, input logic [VAL_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_domain(input longint lo, input longint hi);
    dom_lo = lo;
    dom_hi = hi;
    set_reg(REG_DOMAIN_LOW, lo[31:0]);
    set_reg(REG_DOMAIN_HIGH, hi[31:0]);
  endtask

  // Pick a random domain, extremes and degenerate ones included
  task automatic random_domain();
    longint lo, hi;
    case ($urandom_range(5))
      0: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
      1: begin
        lo = $signed($urandom);
        hi = lo + $urandom_range(1, 5000);
        if (hi > 64'sd2147483647) begin hi = 64'sd2147483647; lo = hi - 100; end
      end
      2: begin lo = $signed($urandom); hi = $signed($urandom); end
      3: begin lo = $signed($urandom); hi = lo; end
      default: begin
        lo = longint'($urandom_range(0, 2097152)) - 1048576;
        hi = lo + $urandom_range(1, 4194304);
      end
    endcase
    set_domain(lo, hi);
  endtask

  // Pick a query near or inside the domain most of the time
  function automatic logic [VAL_W-1:0] pick_query();
    longint span, q;
    span = dom_hi - dom_lo;
    if (span < 1) span = 1;
    case ($urandom_range(9))
      0: q = dom_lo;
      1: q = dom_hi;
      2: q = dom_lo - $urandom_range(1, 1000);
      3: q = dom_hi + $urandom_range(1, 1000);
      4: q = $signed($urandom);
      default: q = dom_lo + longint'({$urandom, $urandom} % span);
    endcase
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    return q[31:0];
  endfunction

  // Keep random lengths inside the filled part of the table
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0: return 11'd2;
      1: return 11'd0;
      2: return 11'd1;
      3: return LEN_W'(FILL_N - 1);
      default: return LEN_W'($urandom_range(3, FILL_N - 1));
    endcase
  endfunction

  initial begin
    send_idle_pct  = 12;
    recv_idle_pct  = 77;
    long_stall_req = 1'b0;
    dom_lo = 0;
    dom_hi = 65536;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill every entry the random lengths can reach
    for (int i = 0; i < FILL_N; i++) write_entry(i, $urandom);

    // Directed: extreme entries, bounds and inside points under reset config
    write_entry(0, 32'h8000_0000);
    write_entry(1, 32'h7fff_ffff);
    write_entry(1023, 32'hffff_ffff);
    map_query(32'h0);
    map_query(32'd65536);
    map_query(32'd32768);
    map_query(32'd1);
    map_query(32'd65535);
    map_query(32'h8000_0000);
    map_query(32'h7fff_ffff);
    write_entry(1, 32'h8000_0000);
    write_entry(0, 32'h7fff_ffff);
    map_query(32'd40000);
    drain();

    // Directed: reject mode at, below and above the bounds
    set_reg(REG_CLIP_MODE, 32'd0);
    map_query(32'h0);
    map_query(32'd65536);
    map_query(32'hffff_ffff);
    map_query(32'd65537);
    map_query(32'd20000);
    drain();

    // Directed: equal and reversed bounds, widest domain at saturated length
    set_domain(100, 100);
    map_query(32'd100);
    map_query(32'h0);
    drain();
    set_domain(5, -5);
    map_query(32'h0);
    drain();
    set_domain(-64'sd2147483648, 64'sd2147483647);
    set_reg(REG_TABLE_LENGTH, 32'd2047);
    write_entry(511, $urandom);
    write_entry(512, $urandom);
    write_entry(584, $urandom);
    write_entry(585, $urandom);
    map_query(32'h8000_0000);
    map_query(32'h7fff_ffff);
    map_query(32'h8000_0001);
    map_query(32'h0);
    map_query(32'h1234_5678);
    drain();

    // Random: three idling regimes, several register settings each
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 77; recv_idle_pct = 12; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      for (int s = 0; s < 4; s++) begin
        int n_items;
        random_domain();
        set_reg(REG_CLIP_MODE, $urandom_range(1));
        set_reg(REG_TABLE_LENGTH, VAL_W'(pick_length()));
        n_items = 30;
        if (ph == 2 && s == 1) begin
          long_stall_req = 1'b1;
          n_items = 90;
        end
        for (int k = 0; k < n_items; k++) begin
          if ($urandom_range(99) < 25) write_entry($urandom_range(1023), $urandom);
          else map_query(pick_query());
        end
        drain();
      end
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== lut_1d_linear_interp_top.f =====
+incdir+hdl
hdl/lli_pkg.sv
hdl/lli_div_cell.sv
hdl/lli_div_chain.sv
hdl/lut_1d_linear_interp_top.sv
hdl/lli_checker.sv
tb/lut_1d_linear_interp_checker.sv
tb/testbench.sv
